@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl top level (indexed_sequence_store)
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ISQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ISQ_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ISQ_ASSERT(label, clk, rstn, prop)
`define ISQ_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

@@ hw/rtl/isq_pkg.sv @@
// types, codes and widths for the indexed sequence store
// no dependencies
package isq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int CNT_W        = 7;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] last_value;
    } rsp_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic step;
        logic place;
        logic fetch;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ hw/rtl/isq_if.sv @@
// request and response channel interfaces
// depends on isq_pkg
interface isq_req_if;
    logic          valid;
    logic          ready;
    isq_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface isq_rsp_if;
    logic          valid;
    logic          ready;
    isq_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/isq_ctrl.sv @@
// sequencing state machine for the indexed sequence store
// depends on isq_pkg; drives the datapath through ctrl_cmd_t
module isq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  isq_pkg::ctrl_sts_t    sts,
    output isq_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/isq_dp.sv @@
// datapath: entry memory, count, shift sweep and response register
// depends on isq_pkg and isq_if; commanded by isq_ctrl
module isq_dp #(
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  isq_pkg::req_t      req_data,
    input  isq_pkg::ctrl_cmd_t cmd,
    output isq_pkg::ctrl_sts_t sts,
    isq_rsp_if.source          rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W;
    localparam int DW = isq_pkg::DATA_W;

    logic signed [DW-1:0] store_mem [CAPACITY];

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        moves_reg, moves_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [AW-1:0]        place_addr_reg, place_addr_next;
    logic                 do_ins_reg, do_ins_next;
    logic                 do_rem_reg, do_rem_next;
    logic                 do_rd_reg, do_rd_next;
    isq_pkg::status_t     status_reg, status_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] rdata_a_reg, rdata_b_reg;
    logic signed [DW-1:0] first_reg, first_next;
    isq_pkg::rsp_t        rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 re_a, re_b;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;

    logic [PW-1:0]        pos_ext, cnt_ext, ins_at;
    logic                 full;

    assign pos_ext = PW'(req_data.position);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    assign sts.sweep_done = (moves_reg == '0) && !wr_pend_reg;
    assign sts.out_free   = !rsp_valid_reg || rsp.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    always_comb
    begin
        count_next      = count_reg;
        moves_next      = moves_reg;
        src_next        = src_reg;
        wr_addr_next    = wr_addr_reg;
        wr_pend_next    = 1'b0;
        place_addr_next = place_addr_reg;
        do_ins_next     = do_ins_reg;
        do_rem_next     = do_rem_reg;
        do_rd_next      = do_rd_reg;
        status_next     = status_reg;
        val_next        = val_reg;
        first_next      = first_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        ins_at          = pos_ext;
        re_a            = 1'b0;
        re_b            = 1'b0;
        raddr_a         = src_reg;
        raddr_b         = AW'(count_reg - CW'(1));
        we              = 1'b0;
        waddr           = wr_addr_reg;
        wdata           = rdata_a_reg;

        // request decode and range checks
        if (cmd.load)
        begin
            do_ins_next = 1'b0;
            do_rem_next = 1'b0;
            do_rd_next  = 1'b0;
            status_next = isq_pkg::ST_OK;
            val_next    = req_data.value_in;
            moves_next  = '0;
            case (isq_pkg::action_t'(req_data.action))
                isq_pkg::ACT_APPEND:
                begin
                    ins_at = cnt_ext;
                    if (full)
                    begin
                        status_next = isq_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_ins_next = 1'b1;
                    end
                end
                isq_pkg::ACT_INSERT:
                begin
                    if (pos_ext > cnt_ext)
                    begin
                        status_next = isq_pkg::ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = isq_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_ins_next = 1'b1;
                    end
                end
                isq_pkg::ACT_REMOVE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = isq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        do_rem_next = 1'b1;
                    end
                end
                isq_pkg::ACT_READ:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = isq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        do_rd_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = isq_pkg::ST_RANGE;
                end
            endcase
            place_addr_next = AW'(ins_at);
            if (do_ins_next)
            begin
                moves_next = CW'(cnt_ext - ins_at);
                src_next   = AW'(cnt_ext - PW'(1));
            end
            else if (do_rem_next)
            begin
                moves_next = CW'(cnt_ext - pos_ext - PW'(1));
                src_next   = AW'(pos_ext + PW'(1));
            end
        end

        // one entry moved per cycle: read source, write neighbor next cycle
        if (wr_pend_reg)
        begin
            we = 1'b1;
        end
        if (cmd.step && (moves_reg != '0))
        begin
            re_a         = 1'b1;
            raddr_a      = src_reg;
            moves_next   = moves_reg - CW'(1);
            wr_pend_next = 1'b1;
            if (do_ins_reg)
            begin
                src_next     = src_reg - AW'(1);
                wr_addr_next = src_reg + AW'(1);
            end
            else
            begin
                src_next     = src_reg + AW'(1);
                wr_addr_next = src_reg - AW'(1);
            end
        end

        if (cmd.place)
        begin
            if (do_ins_reg)
            begin
                we         = 1'b1;
                waddr      = place_addr_reg;
                wdata      = val_reg;
                count_next = count_reg + CW'(1);
            end
            else if (do_rem_reg)
            begin
                count_next = count_reg - CW'(1);
            end
        end

        if (cmd.fetch)
        begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = do_rd_reg ? place_addr_reg : '0;
        end

        if (cmd.emit)
        begin
            if (!do_rd_reg)
            begin
                first_next = rdata_a_reg;
            end
            rsp_next.status      = status_reg;
            rsp_next.read_value  = do_rd_reg ? rdata_a_reg : '0;
            rsp_next.entry_count = isq_pkg::CNT_W'(count_reg);
            rsp_next.first_value = (count_reg == '0) ? '0 : first_next;
            rsp_next.last_value  = (count_reg == '0) ? '0 : rdata_b_reg;
            rsp_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= store_mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= store_mem[raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            moves_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            moves_reg     <= moves_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        wr_addr_reg    <= wr_addr_next;
        place_addr_reg <= place_addr_next;
        do_ins_reg     <= do_ins_next;
        do_rem_reg     <= do_rem_next;
        do_rd_reg      <= do_rd_next;
        status_reg     <= status_next;
        val_reg        <= val_next;
        first_reg      <= first_next;
        rsp_reg        <= rsp_next;
    end

endmodule

@@ hw/rtl/indexed_sequence_store.sv @@
// top level of the indexed sequence store
// depends on isq_pkg, isq_if, isq_ctrl, isq_dp and assert_macros.svh
//
// channel | dir | payload
// req     | in  | action, position, value_in
// rsp     | out | status, read_value, entry_count, first_value, last_value
//
// one request at a time: an insert moves count - index entries and a
// remove moves count - 1 - index; then the count is updated (an insert
// also writes its value), entries are fetched and the response is emitted
// the single memory write port moves one entry per cycle
// a new request is taken while the previous response waits on rsp
// reset clears the count, sweep state and response valid; no clearing pass over the memory
`include "assert_macros.svh"

module indexed_sequence_store #(
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    isq_req_if.sink   req,
    isq_rsp_if.source rsp
);

    isq_pkg::ctrl_cmd_t cmd;
    isq_pkg::ctrl_sts_t sts;

    assign req.ready = cmd.ready;

    isq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    isq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

    `ISQ_ASSERT(a_one_request_at_a_time, clk, rst_n, (req.valid && req.ready) |=> !req.ready)
    `ISQ_ASSERT(a_emit_shows_response, clk, rst_n, cmd.emit |=> rsp.valid)
    `ISQ_ASSERT(a_single_command, clk, rst_n, $onehot0({cmd.load, cmd.step, cmd.place, cmd.fetch, cmd.emit}))
    `ISQ_ASSERT_NEVER(a_emit_while_blocked, clk, rst_n, cmd.emit && rsp.valid && !rsp.ready)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for indexed_sequence_store: directed and random requests with random idling
// depends on isq_pkg, isq_if and the indexed_sequence_store rtl

class store_tracker;
    localparam int CAP = isq_pkg::CAPACITY_DEF;

    logic signed [31:0] entries[$];
    isq_pkg::rsp_t      pending_rsp[$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    function void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void note_request(isq_pkg::req_t r);
        isq_pkg::rsp_t e;
        int            pos;
        e = '0;
        e.status = isq_pkg::ST_OK;
        pos = int'(r.position);
        case (isq_pkg::action_t'(r.action))
            isq_pkg::ACT_APPEND:
                if (entries.size() >= CAP)
                    e.status = isq_pkg::ST_FULL;
                else
                    entries.push_back(r.value_in);
            isq_pkg::ACT_INSERT:
                if (pos > entries.size())
                    e.status = isq_pkg::ST_RANGE;
                else if (entries.size() >= CAP)
                    e.status = isq_pkg::ST_FULL;
                else
                    entries.insert(pos, r.value_in);
            isq_pkg::ACT_REMOVE:
                if (pos >= entries.size())
                    e.status = isq_pkg::ST_RANGE;
                else
                    entries.delete(pos);
            default:
                if (pos >= entries.size())
                    e.status = isq_pkg::ST_RANGE;
                else
                    e.read_value = entries[pos];
        endcase
        e.entry_count = isq_pkg::CNT_W'(entries.size());
        if (entries.size() > 0)
        begin
            e.first_value = entries[0];
            e.last_value  = entries[entries.size() - 1];
        end
        pending_rsp.push_back(e);
    endfunction

    function void check_response(isq_pkg::rsp_t got);
        isq_pkg::rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            flag_error("response with no request outstanding");
            return;
        end
        e = pending_rsp.pop_front();
        if (got.status !== e.status || got.read_value !== e.read_value ||
            got.entry_count !== e.entry_count || got.first_value !== e.first_value ||
            got.last_value !== e.last_value)
            flag_error($sformatf({"exp st=%0d rd=%0d cnt=%0d first=%0d last=%0d, ",
                                  "got st=%0d rd=%0d cnt=%0d first=%0d last=%0d"},
                                 e.status, e.read_value, e.entry_count, e.first_value,
                                 e.last_value, got.status, got.read_value,
                                 got.entry_count, got.first_value, got.last_value));
    endfunction
endclass

module tb_top;
    import isq_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 200;

    logic clk;
    logic rst_n;

    isq_req_if req_ch ();
    isq_rsp_if rsp_ch ();

    indexed_sequence_store #(.CAPACITY(CAP)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    store_tracker tracker;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_rsp;
    int  gen_count;
    bit  growing;
    int  idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // response side: random stalls plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // handshake monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (req_ch.valid && req_ch.ready)
                    tracker.note_request(req_ch.data);
                if (rsp_ch.valid && rsp_ch.ready)
                    tracker.check_response(rsp_ch.data);
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic issue_request(action_t act, int pos, logic signed [31:0] val);
        req_t r;
        r.action   = act;
        r.position = pos[POS_W-1:0];
        r.value_in = val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        case (act)
            ACT_APPEND:
                if (gen_count < CAP)
                    gen_count++;
            ACT_INSERT:
                if (pos <= gen_count && gen_count < CAP)
                    gen_count++;
            ACT_REMOVE:
                if (pos < gen_count)
                    gen_count--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int n_items);
        int      sel;
        int      pos;
        action_t act;
        for (int i = 0; i < n_items; i++)
        begin
            if (gen_count == 0)
                growing = 1'b1;
            else if (gen_count == CAP && $urandom_range(3) == 0)
                growing = 1'b0;
            sel = $urandom_range(99);
            if (growing)
                act = sel < 40 ? ACT_APPEND : sel < 70 ? ACT_INSERT :
                      sel < 85 ? ACT_READ : ACT_REMOVE;
            else
                act = sel < 10 ? ACT_APPEND : sel < 20 ? ACT_INSERT :
                      sel < 45 ? ACT_READ : ACT_REMOVE;
            // mostly legal indexes, some noise over the whole field
            if ($urandom_range(99) < 8)
                pos = $urandom_range(127);
            else if (act == ACT_INSERT)
                pos = $urandom_range(gen_count);
            else if (gen_count > 0)
                pos = $urandom_range(gen_count - 1);
            else
                pos = $urandom_range(127);
            issue_request(act, pos, pick_value());
        end
    endtask

    initial
    begin
        tracker        = new();
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rsp       = 1'b0;
        gen_count      = 0;
        growing        = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, ends and middle of the sequence
        issue_request(ACT_READ,   0,   32'sh0);
        issue_request(ACT_REMOVE, 0,   32'sh0);
        issue_request(ACT_INSERT, 1,   32'sh1234_5678);
        issue_request(ACT_READ,   127, 32'sh0);
        issue_request(ACT_APPEND, 0,   32'sh7fff_ffff);
        issue_request(ACT_INSERT, 0,   32'sh8000_0000);
        issue_request(ACT_INSERT, 2,   -32'sd1);
        issue_request(ACT_INSERT, 1,   32'sh0);
        issue_request(ACT_READ,   0,   32'sh0);
        issue_request(ACT_READ,   3,   32'sh0);
        issue_request(ACT_READ,   4,   32'sh0);
        issue_request(ACT_REMOVE, 3,   32'sh0);
        issue_request(ACT_REMOVE, 0,   32'sh0);
        issue_request(ACT_INSERT, 1,   32'sh5555_aaaa);
        issue_request(ACT_REMOVE, 1,   32'sh0);
        issue_request(ACT_REMOVE, 2,   32'sh0);
        issue_request(ACT_INSERT, 127, 32'sh0);
        issue_request(ACT_REMOVE, 64,  32'sh0);
        issue_request(ACT_READ,   1,   32'sh0);
        issue_request(ACT_APPEND, 127, 32'shaaaa_aaaa);

        // no idling, with one long response hold-off
        run_random(60);
        hold_rsp = 1'b1;
        run_random(125);

        send_idle_pct  = 78;
        recv_stall_pct = 0;
        run_random(185);

        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random(185);

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        run_random(185);

        req_ch.valid <= 1'b0;
        while (tracker.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
